/* hdl/psg_register_write_translator_macros.svh */
// Assertion macros for the PSG register write translator.
`ifndef PSG_REGISTER_WRITE_TRANSLATOR_MACROS_SVH
`define PSG_REGISTER_WRITE_TRANSLATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PSG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psg assertion failed");

// Next-cycle implication, checked out of reset
`define PSG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psg assertion failed");

`endif

/* hdl/psg_pkg.sv */
// Package: constants, command/status types, volume table and side mask for the translator.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

    localparam int BASE_OCTAVE_SHIFT = 17;
    localparam int MAPPED_CHANNELS   = 12;
    localparam int STORE_CH          = 12;
    localparam int VOICES            = 6;

    // dividend is ratio << (shift + octave); quotient bits 24..9 must exist
    localparam int RATIO_W = 8;
    localparam int DIV_RAW = RATIO_W + BASE_OCTAVE_SHIFT + 7;
    localparam int DIV_W   = (DIV_RAW > 25) ? DIV_RAW : 25;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    localparam logic [7:0]  RATIO_7M = 8'd147;
    localparam logic [7:0]  RATIO_8M = 8'd164;
    localparam logic [15:0] LO_7M    = 16'd74;
    localparam logic [15:0] HI_7M    = 16'd18767;
    localparam logic [15:0] LO_8M    = 16'd82;
    localparam logic [15:0] HI_8M    = 16'd20971;

    localparam logic [4:0] REG_VOLUME  = 5'h00;
    localparam logic [4:0] REG_TONE    = 5'h08;
    localparam logic [4:0] REG_OCTAVE  = 5'h10;
    localparam logic [4:0] REG_TONE_EN = 5'h14;
    localparam logic [7:0] OCT_KEEP    = 8'h77;

    typedef enum logic [1:0] {
        OFS_FREQ_LO = 2'd0,
        OFS_FREQ_HI = 2'd1,
        OFS_VOLUME  = 2'd2,
        OFS_WAVE    = 2'd3
    } t_psg_ofs;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic adj;
        logic emit;
        logic sel;
    } t_psg_cmd;

    // datapath -> controller
    typedef struct packed {
        logic     mapped;
        t_psg_ofs ofs;
        logic     wave_changed;
        logic     div_last;
        logic     out_free;
    } t_psg_sts;

    function automatic logic [7:0] vol_rom(input logic [5:0] idx);
        logic [7:0] v;
        begin
            if (idx < 6'd16)       v = 8'h00;
            else if (idx < 6'd32)  v = 8'h11;
            else if (idx < 6'd41)  v = 8'h22;
            else if (idx < 6'd46)  v = 8'h33;
            else if (idx < 6'd51)  v = 8'h44;
            else if (idx < 6'd54)  v = 8'h55;
            else if (idx < 6'd56)  v = 8'h66;
            else if (idx < 6'd59)  v = 8'h77;
            else if (idx < 6'd61)  v = 8'h88;
            else if (idx < 6'd63)  v = 8'h99;
            else                   v = 8'hAA;
            return v;
        end
    endfunction

    function automatic logic [7:0] side_mask(input logic [1:0] sel);
        logic [7:0] m;
        begin
            case (sel)
                2'd0:    m = 8'h00;
                2'd1:    m = 8'h0F;
                2'd2:    m = 8'hF0;
                default: m = 8'hFF;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/psg_register_write_translator.sv */
// Top level: PSG register write translator, controller plus datapath.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_psg_address, i_psg_data
//  out     | output    | o_out_valid/i_out_stall | o_chip_index, o_target_register,
//          |           |                       | o_target_data, o_last_write
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_clock_select
//
// Frequency writes hold the input through the accept state, the clamp/octave (prep) state,
// one radix-2 divider step per dividend bit, one fix-up state and two output states.
// Volume writes pass through accept, prep and the final output state; changed waveforms
// use both output states; unmapped channels and unchanged waveforms return to idle after prep.
// Synchronous active-low reset restores clock select 1 and the shadow values.
// Output stalls hold the controller in its output states; the input stalls meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module psg_register_write_translator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [5:0]  i_psg_address,
    input  wire  [7:0]  i_psg_data,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_clock_select,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_chip_index,
    output logic [4:0]  o_target_register,
    output logic [7:0]  o_target_data,
    output logic        o_last_write
);

`include "psg_register_write_translator_macros.svh"

    psg_pkg::t_psg_cmd cmd;
    psg_pkg::t_psg_sts sts;
    logic              busy;

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    psg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    psg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_psg_address     (i_psg_address),
        .i_psg_data        (i_psg_data),
        .i_cfg_valid       (i_cfg_valid),
        .i_clock_select    (i_clock_select),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_chip_index      (o_chip_index),
        .o_target_register (o_target_register),
        .o_target_data     (o_target_data),
        .o_last_write      (o_last_write)
    );

    // an accepted word keeps the block busy in the next cycle
    `PSG_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // a taken non-final output word is followed at once by the final one
    `PSG_ASSERT_NXT(a_second_word_follows, o_out_valid && !i_out_stall && !o_last_write, o_out_valid && o_last_write)
    // an input is never accepted during a divide or output sequence
    `PSG_ASSERT_IMP(a_no_accept_when_busy, busy, o_in_stall)

endmodule
`default_nettype wire

/* hdl/psg_ctrl.sv */
// Controller state machine: sequences accept, divide and the two output words.
`timescale 1ns / 1ps
`default_nettype none
module psg_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  psg_pkg::t_psg_sts   i_sts,
    output psg_pkg::t_psg_cmd   o_cmd,
    output logic                o_busy
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIV, S_ADJ, S_OUT0, S_OUT1
    } t_state;

    t_state r_state, n_state;

    // command decode
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (!i_sts.mapped) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (i_sts.ofs)
                        psg_pkg::OFS_FREQ_LO, psg_pkg::OFS_FREQ_HI: begin
                            o_cmd.prep = 1'b1;
                            n_state    = S_DIV;
                        end
                        psg_pkg::OFS_VOLUME: n_state = S_OUT1;
                        default:  n_state = i_sts.wave_changed ? S_OUT0 : S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_ADJ;
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = S_OUT0;
            end
            S_OUT0: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_OUT1;
                end
            end
            S_OUT1: begin
                o_cmd.sel = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_busy  <= (n_state != S_IDLE);
        end
    end

endmodule
`default_nettype wire

/* hdl/psg_dp.sv */
// Datapath: channel state, shadow registers, radix-2 divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module psg_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  psg_pkg::t_psg_cmd   i_cmd,
    output psg_pkg::t_psg_sts   o_sts,
    input  wire  [5:0]          i_psg_address,
    input  wire  [7:0]          i_psg_data,
    input  wire                 i_cfg_valid,
    input  wire                 i_clock_select,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    output logic                o_chip_index,
    output logic [4:0]          o_target_register,
    output logic [7:0]          o_target_data,
    output logic                o_last_write
);

    localparam int DW = psg_pkg::DIV_W;
    localparam int CW = psg_pkg::CNT_W;

    logic             r_clk_sel;
    logic [5:0]       r_addr;
    logic [7:0]       r_data;
    logic [15:0]      r_freq [psg_pkg::STORE_CH];
    logic [1:0]       r_wave [psg_pkg::STORE_CH];
    logic [7:0]       r_oct_sh [2][3];
    logic [7:0]       r_en_sh  [2][2];
    logic [15:0]      r_w;
    logic [2:0]       r_oct;
    logic [DW-1:0]    r_dq;
    logic [15:0]      r_rem;
    logic [CW-1:0]    r_cnt;
    logic [7:0]       r_tone;

    logic [3:0]       ch;
    logic             chip;
    logic [3:0]       voice_full;
    logic [2:0]       voice;
    logic [1:0]       oreg;
    logic             mapped;
    logic [1:0]       wf;
    logic [15:0]      n_word, clamped, lo, hi;
    logic [3:0]       msb;
    logic [2:0]       n_oct;
    logic [DW-1:0]    dividend;
    logic [16:0]      rem_sh;
    logic             q_bit;
    logic [16:0]      rem_sub;
    logic [15:0]      q16;
    logic [7:0]       q_lo;
    logic [2:0]       oct_adj;
    logic             en_sel;
    logic [7:0]       bitv;
    logic [7:0]       oct_byte;
    logic [7:0]       keep_mask;
    logic             out_free;
    logic [4:0]       res_reg;
    logic [7:0]       res_data;
    logic             res_last;

    // channel decode
    assign ch         = r_addr[5:2];
    assign chip       = (ch >= 4'(psg_pkg::VOICES));
    assign voice_full = ch - (chip ? 4'(psg_pkg::VOICES) : 4'd0);
    assign voice      = voice_full[2:0];
    assign oreg       = voice[2:1];
    assign mapped     = (ch < 4'(psg_pkg::MAPPED_CHANNELS));
    assign wf         = r_data[7:6];
    assign en_sel     = wf[1] & wf[0];
    assign bitv       = 8'd1 << voice;
    assign out_free   = !o_out_valid || !i_out_stall;

    // frequency merge, clamp and octave from the leading one
    always_comb begin
        n_word = r_freq[mapped ? ch : 4'd0];
        if (r_addr[0]) n_word[15:8] = r_data;
        else           n_word[7:0]  = r_data;
        lo = r_clk_sel ? psg_pkg::LO_8M : psg_pkg::LO_7M;
        hi = r_clk_sel ? psg_pkg::HI_8M : psg_pkg::HI_7M;
        if (n_word < lo)      clamped = lo;
        else if (n_word > hi) clamped = hi;
        else                  clamped = n_word;
        msb = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (clamped[i]) msb = 4'(i);
        end
        n_oct = (msb >= 4'd13) ? 3'd7 : 3'(msb - 4'd6);
        dividend = DW'(r_clk_sel ? psg_pkg::RATIO_8M : psg_pkg::RATIO_7M)
                   << (psg_pkg::BASE_OCTAVE_SHIFT + int'(n_oct));
    end

    // one restoring divide step
    assign rem_sh  = {r_rem, r_dq[DW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_w});
    assign rem_sub = rem_sh - {1'b0, r_w};

    // quotient range fix-up
    always_comb begin
        q16     = r_dq[9 +: 16];
        oct_adj = r_oct;
        if (q16 > 16'd511) begin
            q_lo    = q16[8:1];
            oct_adj = r_oct - 3'd1;
        end else if (q16 < 16'd256) begin
            q_lo = 8'd0;
        end else begin
            q_lo = q16[7:0];
        end
    end

    // result word select
    always_comb begin
        keep_mask = voice[0] ? (psg_pkg::OCT_KEEP ^ 8'h70) : (psg_pkg::OCT_KEEP ^ 8'h07);
        oct_byte  = (r_oct_sh[chip][oreg] & keep_mask)
                    | (voice[0] ? {1'b0, r_oct, 4'd0} : {5'd0, r_oct});
        res_last  = i_cmd.sel;
        case (psg_pkg::t_psg_ofs'(r_addr[1:0]))
            psg_pkg::OFS_VOLUME: begin
                res_reg  = psg_pkg::REG_VOLUME + 5'(voice);
                res_data = psg_pkg::vol_rom(r_data[5:0]) & psg_pkg::side_mask(r_data[7:6]);
            end
            psg_pkg::OFS_WAVE: begin
                if (!i_cmd.sel) begin
                    res_reg  = psg_pkg::REG_TONE_EN | 5'(en_sel);
                    res_data = r_en_sh[chip][en_sel] | bitv;
                end else begin
                    res_reg  = psg_pkg::REG_TONE_EN | 5'(!en_sel);
                    res_data = r_en_sh[chip][!en_sel] & ~bitv;
                end
            end
            default: begin
                if (!i_cmd.sel) begin
                    res_reg  = psg_pkg::REG_TONE + 5'(voice);
                    res_data = r_tone;
                end else begin
                    res_reg  = psg_pkg::REG_OCTAVE + 5'(oreg);
                    res_data = oct_byte;
                end
            end
        endcase
    end

    // status to controller
    always_comb begin
        o_sts.mapped       = mapped;
        o_sts.ofs          = psg_pkg::t_psg_ofs'(r_addr[1:0]);
        o_sts.wave_changed = (wf != r_wave[mapped ? ch : 4'd0]);
        o_sts.div_last     = (r_cnt == '0);
        o_sts.out_free     = out_free;
    end

    // control state and model state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_sel   <= 1'b1;
            o_out_valid <= 1'b0;
            for (int c = 0; c < psg_pkg::STORE_CH; c++) begin
                r_freq[c] <= '0;
                r_wave[c] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                for (int j = 0; j < 3; j++) r_oct_sh[k][j] <= '0;
                r_en_sh[k][0] <= 8'h3F;
                r_en_sh[k][1] <= 8'h00;
            end
        end else begin
            if (i_cfg_valid) r_clk_sel <= i_clock_select;
            if (i_cmd.prep) r_freq[ch] <= n_word;
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                if (r_addr[1:0] == psg_pkg::OFS_WAVE) begin
                    r_en_sh[chip][res_reg[0]] <= res_data;
                    if (i_cmd.sel) r_wave[ch] <= wf;
                end else if (r_addr[1] == 1'b0 && i_cmd.sel) begin
                    r_oct_sh[chip][oreg] <= res_data;
                end
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_psg_address;
            r_data <= i_psg_data;
        end
        if (i_cmd.prep) begin
            r_w   <= clamped;
            r_oct <= n_oct;
            r_dq  <= dividend;
            r_rem <= '0;
            r_cnt <= CW'(DW - 1);
        end
        if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.adj) begin
            r_tone <= ~q_lo;
            r_oct  <= oct_adj;
        end
        if (i_cmd.emit) begin
            o_chip_index      <= chip;
            o_target_register <= res_reg;
            o_target_data     <= res_data;
            o_last_write      <= res_last;
        end
    end

endmodule
`default_nettype wire
